/* hdl/rrq_pkg.sv */
// Package: shared types and constants for the round-robin run queue.
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int MAX_THREADS = 64;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 7;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SELECT = 2'd2,
    REQ_FREEZE = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    STS_OK            = 3'd0,
    STS_EMPTY         = 3'd1,
    STS_NOT_QUEUED    = 3'd2,
    STS_NONE_RUNNABLE = 3'd3,
    STS_ALREADY       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REM_HEAD,
    S_REM_WALK,
    S_REM_LINK,
    S_SEL,
    S_HOLD
  } fsm_state_t;

  typedef struct packed {
    req_kind_t req_type;
    slot_t     thread_id;
    logic      frozen_value;
  } req_t;

  typedef struct packed {
    slot_t   selected_thread;
    logic    selected_valid;
    status_t status;
    cnt_t    queue_count;
  } rsp_t;

endpackage

/* hdl/round_robin_run_queue_unit.sv */
// Round-robin run queue: linked FIFO of thread slots in a next-pointer memory.
`timescale 1ns / 1ps

// Keeps up to MAX_THREADS thread slots in a round-robin FIFO whose order lives
// in a 64-entry next-pointer memory (one synchronous read port, read data
// registered, one write port); head, tail, entry count and the per-slot
// queued and frozen flags are flip-flops cleared at reset, so the block is
// ready in the first cycle after reset with no clearing pass. One request is
// processed at a time. Insert, set frozen, and requests that fail pass from
// acceptance through S_EXEC and S_HOLD to a result in the output register;
// remove of the head adds S_REM_HEAD for the read of its successor link.
// Select next adds S_SEL, which moves N threads from head to tail (one per
// cycle, limited by the dependent read of the link memory); when every
// queued thread is frozen N is the queue length, at most 64. Remove of a
// thread further back adds S_REM_WALK, where the predecessor search walks
// the links one per cycle, then S_REM_LINK unless the thread is the tail.
// A finished result waits in the output register while the next request is
// accepted and run, but that request waits in S_HOLD while the output stalls.
// A select that finds every queued thread frozen does one full pass, leaves
// the order as it was and reports none runnable.
module round_robin_run_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rrq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rrq_pkg::rsp_t rsp
);
  import rrq_pkg::*;

  // Control state
  fsm_state_t             state, state_next;
  slot_t                  head, head_next;
  slot_t                  tail, tail_next;
  cnt_t                   count, count_next;
  logic [MAX_THREADS-1:0] queued, queued_next;
  logic [MAX_THREADS-1:0] frozen, frozen_next;
  cnt_t                   steps, steps_next;
  logic                   out_valid, out_valid_next;

  // Payload registers
  req_t    cur, cur_next;
  slot_t   walk_p, walk_p_next;
  slot_t   res_sel, res_sel_next;
  logic    res_valid, res_valid_next;
  status_t res_status, res_status_next;
  rsp_t    out_data, out_data_next;

  // Link memory and its ports
  slot_t link_mem [MAX_THREADS];
  slot_t link_rd;
  slot_t rd_addr;
  logic  we;
  slot_t wr_addr;
  slot_t wr_data;
  logic  fwd_hit;
  slot_t fwd_data;
  slot_t link_q;
  logic  out_free;

  // Read-before-write memory; a write to the address read in the same cycle
  // is forwarded on the following cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[wr_addr] <= wr_data;
    end
    link_rd  <= link_mem[rd_addr];
    fwd_data <= wr_data;
  end

  assign link_q   = fwd_hit ? fwd_data : link_rd;
  assign out_free = !out_valid || !rsp_stall;

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      queued    <= '0;
      frozen    <= '0;
      steps     <= '0;
      out_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      queued    <= queued_next;
      frozen    <= frozen_next;
      steps     <= steps_next;
      out_valid <= out_valid_next;
      fwd_hit   <= we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    walk_p     <= walk_p_next;
    res_sel    <= res_sel_next;
    res_valid  <= res_valid_next;
    res_status <= res_status_next;
    out_data   <= out_data_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    queued_next     = queued;
    frozen_next     = frozen;
    steps_next      = steps;
    cur_next        = cur;
    walk_p_next     = walk_p;
    res_sel_next    = res_sel;
    res_valid_next  = res_valid;
    res_status_next = res_status;
    out_data_next   = out_data;
    out_valid_next  = out_valid && rsp_stall;
    rd_addr         = head;
    we              = 1'b0;
    wr_addr         = tail;
    wr_data         = head;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next   = req;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_sel_next    = '0;
        res_valid_next  = 1'b0;
        res_status_next = STS_OK;
        state_next      = S_HOLD;
        case (cur.req_type)
          REQ_INSERT: begin
            if (queued[cur.thread_id]) begin
              res_status_next = STS_ALREADY;
            end else begin
              if (count == '0) begin
                head_next = cur.thread_id;
              end else begin
                we      = 1'b1;
                wr_addr = tail;
                wr_data = cur.thread_id;
              end
              tail_next                   = cur.thread_id;
              queued_next[cur.thread_id]  = 1'b1;
              count_next                  = count + cnt_t'(1);
            end
          end
          REQ_REMOVE: begin
            if (!queued[cur.thread_id]) begin
              res_status_next = STS_NOT_QUEUED;
            end else if (count == cnt_t'(1)) begin
              head_next                  = '0;
              tail_next                  = '0;
              queued_next[cur.thread_id] = 1'b0;
              count_next                 = count - cnt_t'(1);
            end else if (head == cur.thread_id) begin
              rd_addr    = cur.thread_id;
              state_next = S_REM_HEAD;
            end else begin
              rd_addr     = head;
              walk_p_next = head;
              state_next  = S_REM_WALK;
            end
          end
          REQ_SELECT: begin
            if (count == '0) begin
              res_status_next = STS_EMPTY;
            end else if (count == cnt_t'(1)) begin
              // single thread: rotation changes nothing
              if (frozen[head]) begin
                res_status_next = STS_NONE_RUNNABLE;
              end else begin
                res_sel_next   = head;
                res_valid_next = 1'b1;
              end
            end else begin
              rd_addr    = head;
              steps_next = '0;
              state_next = S_SEL;
            end
          end
          REQ_FREEZE: begin
            frozen_next[cur.thread_id] = cur.frozen_value;
          end
          default: begin
            res_status_next = STS_NOT_QUEUED;
          end
        endcase
      end

      S_REM_HEAD: begin
        head_next                  = link_q;
        queued_next[cur.thread_id] = 1'b0;
        count_next                 = count - cnt_t'(1);
        state_next                 = S_HOLD;
      end

      S_REM_WALK: begin
        // link_q is the successor of walk_p
        if (link_q == cur.thread_id) begin
          if (tail == cur.thread_id) begin
            tail_next                  = walk_p;
            queued_next[cur.thread_id] = 1'b0;
            count_next                 = count - cnt_t'(1);
            state_next                 = S_HOLD;
          end else begin
            rd_addr    = cur.thread_id;
            state_next = S_REM_LINK;
          end
        end else begin
          walk_p_next = link_q;
          rd_addr     = link_q;
        end
      end

      S_REM_LINK: begin
        we                         = 1'b1;
        wr_addr                    = walk_p;
        wr_data                    = link_q;
        queued_next[cur.thread_id] = 1'b0;
        count_next                 = count - cnt_t'(1);
        state_next                 = S_HOLD;
      end

      S_SEL: begin
        // move head to tail; link_q is the successor of head
        we         = 1'b1;
        wr_addr    = tail;
        wr_data    = head;
        tail_next  = head;
        head_next  = link_q;
        rd_addr    = link_q;
        steps_next = steps + cnt_t'(1);
        if (!frozen[head]) begin
          res_sel_next   = head;
          res_valid_next = 1'b1;
          state_next     = S_HOLD;
        end else if (steps + cnt_t'(1) == count) begin
          // full pass, order is back where it started
          res_status_next = STS_NONE_RUNNABLE;
          state_next      = S_HOLD;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          out_data_next.selected_thread = res_sel;
          out_data_next.selected_valid  = res_valid;
          out_data_next.status          = res_status;
          out_data_next.queue_count     = count;
          out_valid_next                = 1'b1;
          state_next                    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    $countones(queued) == int'(count))
    else $error("entry count disagrees with queued flags");

  a_ends_queued: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (queued[head] && queued[tail]))
    else $error("head or tail slot not queued");

  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    (count == cnt_t'(1)) |-> (head == tail))
    else $error("single-entry queue with head different from tail");

  a_sel_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> (steps < count))
    else $error("select rotation ran past one full pass");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");
`endif

endmodule
